### hw/rtl/astt_pkg.sv
// ----------------------------------------------------------------------------
// astt_pkg
// Types and constants shared by the alarm and sensor trigger table.
// ----------------------------------------------------------------------------
package astt_pkg;

  localparam int unsigned ALARM_SLOTS_DEF  = 16;
  localparam int unsigned SENSOR_SLOTS_DEF = 8;
  localparam logic [31:0] FLOOR_RESET = 32'd1000000000;

  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_ADD_P  = 3'd1;
  localparam logic [2:0] MODE_ADD_R  = 3'd2;
  localparam logic [2:0] MODE_ADD_A  = 3'd3;
  localparam logic [2:0] MODE_ADD_S  = 3'd4;
  localparam logic [2:0] MODE_UPDATE = 3'd5;
  localparam logic [2:0] MODE_REMOVE = 3'd6;

  localparam logic [1:0] SRC_PERIODIC = 2'd0;
  localparam logic [1:0] SRC_ONESHOT  = 2'd1;
  localparam logic [1:0] SRC_SENSOR   = 2'd2;

  localparam logic [1:0] KIND_TEMP = 2'd0;
  localparam logic [1:0] KIND_LUMI = 2'd1;

  localparam logic [2:0] OP_EQ = 3'd0;
  localparam logic [2:0] OP_NE = 3'd1;
  localparam logic [2:0] OP_GT = 3'd2;
  localparam logic [2:0] OP_LT = 3'd3;
  localparam logic [2:0] OP_GE = 3'd4;
  localparam logic [2:0] OP_LE = 3'd5;

  typedef struct packed {
    logic [2:0]         mode;
    logic [31:0]        now_seconds;
    logic [15:0]        callback_id;
    logic [31:0]        time_value;
    logic [1:0]         sensor_kind;
    logic [2:0]         compare_op;
    logic signed [23:0] threshold;
    logic signed [23:0] temp_sample;
    logic signed [23:0] lumi_sample;
  } in_item_t;

  typedef struct packed {
    logic [15:0] fired_callback;
    logic [1:0]  source;
    logic        status;
    logic        last;
  } out_item_t;

endpackage

### hw/rtl/alarm_and_sensor_trigger_table_unit.sv
// ----------------------------------------------------------------------------
// alarm_and_sensor_trigger_table_unit
// Table of periodic and one-shot alarms plus latched sensor triggers.
// ----------------------------------------------------------------------------
// Usage: an item is taken on the in_ channel (valid/ready) and carries a mode
// and the current time. A tick scans the tables one slot per cycle while the
// output is not stalled: periodic alarms, then one-shot alarms (both only
// when now_seconds >= clock_valid_floor), then sensor triggers, and emits one
// beat on the out_ channel for each firing, with last set on the final beat.
// Adds that find a full table give one beat with status 1.
// One shared compare/compact step walks the tables; a remove scans the alarm
// table, then the sensor table. Each slot freed by a one-shot or a remove
// adds a compaction pass over the rest of its table. A tick with no hit still
// runs its scan before in_ready rises again. Each result beat is held in an
// output register; a stalled receiver holds the scan until the beat is taken.
// Reset empties both tables, zeroes the sensor samples and sets
// clock_valid_floor to 1000000000. cfg_we writes clock_valid_floor; the user
// must do so only while the block is idle, which the block itself does not
// enforce.
// ----------------------------------------------------------------------------
module alarm_and_sensor_trigger_table_unit
  import astt_pkg::*;
#(
  parameter int unsigned ALARM_SLOTS  = ALARM_SLOTS_DEF,
  parameter int unsigned SENSOR_SLOTS = SENSOR_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [31:0] cfg_wdata
);

  localparam int AW = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
  localparam int SW = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;
  localparam int IW = ((AW > SW) ? AW : SW) + 1;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PER   = 7'b0000010,
    ST_ONE   = 7'b0000100,
    ST_SEN   = 7'b0001000,
    ST_ARM   = 7'b0010000,
    ST_SRM   = 7'b0100000,
    ST_SHIFT = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  in_item_t item_r;
  logic [31:0] floor_r;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] sh_r, sh_nxt;        // compaction write pointer
  logic sh_alarm_r, sh_alarm_nxt;     // compaction on alarm table
  logic [ALARM_SLOTS-1:0]  a_val_r;
  logic [ALARM_SLOTS-1:0]  a_per_r;
  logic [15:0] a_cb_r  [ALARM_SLOTS];
  logic [31:0] a_int_r [ALARM_SLOTS];
  logic [31:0] a_due_r [ALARM_SLOTS];
  logic [SENSOR_SLOTS-1:0] s_val_r;
  logic [SENSOR_SLOTS-1:0] s_lat_r;
  logic [44:0] s_ent_r [SENSOR_SLOTS];
  logic signed [23:0] temp_r, lumi_r;
  logic pend_r, pend_nxt;             // held beat waiting for a successor
  out_item_t hold_r, hold_nxt;
  logic ov_r, ov_nxt;
  out_item_t od_r, od_nxt;

  // shared unit: one slot addressed by the scan index
  logic [AW-1:0] ai;
  logic [SW-1:0] si;
  logic a_hit_p, a_hit_o, a_rm, s_hit, s_rm, s_rel;
  logic signed [23:0] s_cur, s_thr;
  logic stall;
  logic emit;
  out_item_t emit_item;
  logic fin;                          // item done, flush held beat as last
  logic [AW-1:0] afree;
  logic [SW-1:0] sfree;
  logic afull, sfull;

  assign ai = idx_r[AW-1:0];
  assign si = idx_r[SW-1:0];
  assign stall = ov_r && !out_ready;
  assign in_ready = (state_r == ST_IDLE) && !stall && !pend_r;

  always_comb begin
    a_hit_p = a_val_r[ai] && a_per_r[ai] && (item_r.now_seconds >= a_due_r[ai]);
    a_hit_o = a_val_r[ai] && !a_per_r[ai] && (item_r.now_seconds >= a_due_r[ai]);
    a_rm    = a_val_r[ai] && (a_cb_r[ai] == item_r.callback_id);
    s_rm    = s_val_r[si] && (s_ent_r[si][15:0] == item_r.callback_id);
    s_thr   = s_ent_r[si][44:21];
    s_cur   = (s_ent_r[si][17:16] == KIND_LUMI) ? lumi_r : temp_r;
    case (s_ent_r[si][20:18])
      OP_EQ:   s_rel = s_cur == s_thr;
      OP_NE:   s_rel = s_cur != s_thr;
      OP_GT:   s_rel = s_cur > s_thr;
      OP_LT:   s_rel = s_cur < s_thr;
      OP_GE:   s_rel = s_cur >= s_thr;
      OP_LE:   s_rel = s_cur <= s_thr;
      default: s_rel = 1'b0;
    endcase
    s_hit = s_val_r[si] && !s_lat_r[si] && s_rel &&
            ((s_ent_r[si][17:16] == KIND_TEMP) || (s_ent_r[si][17:16] == KIND_LUMI));
  end

  // first free slot; tables are compacted so valid is a prefix
  always_comb begin
    afree = '0;
    sfree = '0;
    for (int k = ALARM_SLOTS - 1; k >= 0; k--)
      if (!a_val_r[k]) afree = AW'(k);
    for (int k = SENSOR_SLOTS - 1; k >= 0; k--)
      if (!s_val_r[k]) sfree = SW'(k);
    afull = &a_val_r;
    sfull = &s_val_r;
  end

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    sh_nxt       = sh_r;
    sh_alarm_nxt = sh_alarm_r;
    emit         = 1'b0;
    emit_item    = '0;
    fin          = 1'b0;
    if (!stall) begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            idx_nxt = '0;
            if (in_data.mode == MODE_TICK)
              state_nxt = (in_data.now_seconds >= floor_r) ? ST_PER : ST_SEN;
            else if (in_data.mode == MODE_REMOVE)
              state_nxt = ST_ARM;
          end
        end
        ST_PER: begin
          if (a_hit_p) begin
            emit = 1'b1;
            emit_item = '{a_cb_r[ai], SRC_PERIODIC, 1'b0, 1'b0};
          end
          if (idx_r == IW'(ALARM_SLOTS - 1)) begin
            idx_nxt = '0;
            state_nxt = ST_ONE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        ST_ONE: begin
          if (a_hit_o) begin
            emit = 1'b1;
            emit_item = '{a_cb_r[ai], SRC_ONESHOT, 1'b0, 1'b0};
            sh_nxt = idx_r;
            sh_alarm_nxt = 1'b1;
            state_nxt = ST_SHIFT;
          end else if (idx_r == IW'(ALARM_SLOTS - 1)) begin
            idx_nxt = '0;
            state_nxt = ST_SEN;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        ST_SEN: begin
          if (s_hit) begin
            emit = 1'b1;
            emit_item = '{s_ent_r[si][15:0], SRC_SENSOR, 1'b0, 1'b0};
          end
          if (idx_r == IW'(SENSOR_SLOTS - 1)) begin
            fin = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        ST_ARM: begin
          if (a_rm) begin
            sh_nxt = idx_r;
            sh_alarm_nxt = 1'b1;
            state_nxt = ST_SHIFT;
          end else if (idx_r == IW'(ALARM_SLOTS - 1)) begin
            idx_nxt = '0;
            state_nxt = ST_SRM;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        ST_SRM: begin
          if (s_rm) begin
            sh_nxt = idx_r;
            sh_alarm_nxt = 1'b0;
            state_nxt = ST_SHIFT;
          end else if (idx_r == IW'(SENSOR_SLOTS - 1)) begin
            fin = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        ST_SHIFT: begin
          // move one slot down per cycle while not stalled, then rescan the same index
          if (sh_alarm_r) begin
            if (sh_r >= IW'(ALARM_SLOTS - 1)) begin
              state_nxt = (item_r.mode == MODE_TICK) ? ST_ONE : ST_ARM;
            end else begin
              sh_nxt = sh_r + 1'b1;
            end
          end else begin
            if (sh_r >= IW'(SENSOR_SLOTS - 1)) begin
              state_nxt = ST_SRM;
            end else begin
              sh_nxt = sh_r + 1'b1;
            end
          end
        end
        default: state_nxt = ST_IDLE;
      endcase
    end
  end

  // output: keep one beat in hand so last can be set on the final one
  always_comb begin
    pend_nxt = pend_r;
    hold_nxt = hold_r;
    ov_nxt   = ov_r && !out_ready;
    od_nxt   = od_r;
    if (in_valid && in_ready && (
        (((in_data.mode == MODE_ADD_P) || (in_data.mode == MODE_ADD_R) ||
          (in_data.mode == MODE_ADD_A)) && afull) ||
        ((in_data.mode == MODE_ADD_S) && sfull))) begin
      ov_nxt = 1'b1;
      od_nxt = '{in_data.callback_id,
                 (in_data.mode == MODE_ADD_P) ? SRC_PERIODIC :
                 (in_data.mode == MODE_ADD_S) ? SRC_SENSOR : SRC_ONESHOT,
                 1'b1, 1'b1};
    end
    if (!stall) begin
      if (emit) begin
        if (pend_r) begin
          ov_nxt = 1'b1;
          od_nxt = hold_r;
        end
        pend_nxt = 1'b1;
        hold_nxt = emit_item;
        if (fin) begin
          if (pend_r) begin
            // two beats at once cannot leave; keep new one pending
            pend_nxt = 1'b1;
          end
        end
      end else if (fin && pend_r) begin
        ov_nxt = 1'b1;
        od_nxt = hold_r;
        od_nxt.last = 1'b1;
        pend_nxt = 1'b0;
      end else if (state_r == ST_IDLE && pend_r) begin
        ov_nxt = 1'b1;
        od_nxt = hold_r;
        od_nxt.last = 1'b1;
        pend_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      idx_r      <= '0;
      sh_r       <= '0;
      sh_alarm_r <= 1'b0;
      floor_r    <= FLOOR_RESET;
      a_val_r    <= '0;
      s_val_r    <= '0;
      temp_r     <= '0;
      lumi_r     <= '0;
      pend_r     <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      sh_r       <= sh_nxt;
      sh_alarm_r <= sh_alarm_nxt;
      pend_r     <= pend_nxt;
      ov_r       <= ov_nxt;
      if (cfg_we) floor_r <= cfg_wdata;
      if (in_valid && in_ready) begin
        item_r <= in_data;
        case (in_data.mode)
          MODE_ADD_P, MODE_ADD_R, MODE_ADD_A: begin
            if (!afull) begin
              a_val_r[afree] <= 1'b1;
              a_per_r[afree] <= (in_data.mode == MODE_ADD_P);
              a_cb_r[afree]  <= in_data.callback_id;
              a_int_r[afree] <= (in_data.mode == MODE_ADD_A) ? 32'd0 : in_data.time_value;
              a_due_r[afree] <= (in_data.mode == MODE_ADD_A) ? in_data.time_value :
                                in_data.now_seconds + in_data.time_value;
            end
          end
          MODE_ADD_S: begin
            if (!sfull) begin
              s_val_r[sfree] <= 1'b1;
              s_lat_r[sfree] <= 1'b0;
              s_ent_r[sfree] <= {in_data.threshold, in_data.compare_op,
                                 in_data.sensor_kind, in_data.callback_id};
            end
          end
          MODE_UPDATE: begin
            temp_r <= in_data.temp_sample;
            lumi_r <= in_data.lumi_sample;
          end
          default: begin
          end
        endcase
      end
      if (!stall) begin
        if (state_r == ST_PER && a_hit_p)
          a_due_r[ai] <= item_r.now_seconds + a_int_r[ai];
        if (state_r == ST_SEN && s_hit)
          s_lat_r[si] <= 1'b1;
        if (state_r == ST_SHIFT) begin
          if (sh_alarm_r) begin
            if (sh_r >= IW'(ALARM_SLOTS - 1)) begin
              a_val_r[ALARM_SLOTS-1] <= 1'b0;
            end else begin
              a_val_r[sh_r[AW-1:0]] <= a_val_r[sh_r[AW-1:0] + 1'b1];
              a_per_r[sh_r[AW-1:0]] <= a_per_r[sh_r[AW-1:0] + 1'b1];
              a_cb_r[sh_r[AW-1:0]]  <= a_cb_r[sh_r[AW-1:0] + 1'b1];
              a_int_r[sh_r[AW-1:0]] <= a_int_r[sh_r[AW-1:0] + 1'b1];
              a_due_r[sh_r[AW-1:0]] <= a_due_r[sh_r[AW-1:0] + 1'b1];
            end
          end else begin
            if (sh_r >= IW'(SENSOR_SLOTS - 1)) begin
              s_val_r[SENSOR_SLOTS-1] <= 1'b0;
            end else begin
              s_val_r[sh_r[SW-1:0]] <= s_val_r[sh_r[SW-1:0] + 1'b1];
              s_lat_r[sh_r[SW-1:0]] <= s_lat_r[sh_r[SW-1:0] + 1'b1];
              s_ent_r[sh_r[SW-1:0]] <= s_ent_r[sh_r[SW-1:0] + 1'b1];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    od_r   <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule
